// ===== src/tzts_pkg.sv =====
// ----------------------------------------------------------------------------
// tzts_pkg
// Shared types, constants and helpers for the ToF zone target selector.
// ----------------------------------------------------------------------------
`default_nettype none

package tzts_pkg;

    // Sizing
    localparam int MAX_TARGETS = 4;
    localparam int MAX_ZONES   = 64;
    localparam int NUM_SLOTS   = 4;
    localparam int DIST_W      = 16;
    localparam int STAT_W      = 8;
    localparam int DCNT_W      = 8;
    localparam int ZCNT_W      = 7;
    localparam int TPZ_W       = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int FAR_W       = 15;

    // Good status codes
    localparam logic [STAT_W-1:0] STATUS_GOOD_A = 8'd5;
    localparam logic [STAT_W-1:0] STATUS_GOOD_B = 8'd9;

    // Register reset values
    localparam logic [TPZ_W-1:0]         TPZ_RESET      = 3'd4;
    localparam logic signed [DIST_W-1:0] MIN_DIST_RESET = 16'sd0;
    localparam logic signed [DIST_W-1:0] MAX_DIST_RESET = 16'sd4000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGETS  = 2'd0,
        CFG_MIN_DIST = 2'd1,
        CFG_MAX_DIST = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [TPZ_W-1:0]         targets;
        logic signed [DIST_W-1:0] min_dist;
        logic signed [DIST_W-1:0] max_dist;
    } t_cfg;

    // One zone as received
    typedef struct packed {
        logic [NUM_SLOTS-1:0][DIST_W-1:0] distance;
        logic [NUM_SLOTS-1:0][STAT_W-1:0] status;
        logic [DCNT_W-1:0]                count;
        logic                             last;
    } t_zone_in;

    // Per-zone selection result
    typedef struct packed {
        logic [NUM_SLOTS-1:0] hit;
        logic [DIST_W-1:0]    farthest;
        logic [DIST_W-1:0]    nearest;
        logic                 any;
    } t_zone_res;

    // Running frame values
    typedef struct packed {
        logic [DIST_W-1:0] closest;
        logic [ZCNT_W-1:0] ground_cnt;
        logic [ZCNT_W-1:0] nearest_cnt;
        logic [ZCNT_W-1:0] near_cnt;
    } t_frame;

    // Unsigned minimum where zero means "not yet set"
    function automatic logic [DIST_W-1:0] f_unset_min(
        input logic [DIST_W-1:0] cur,
        input logic [DIST_W-1:0] cand
    );
        return ((cur == '0) || (cand < cur)) ? cand : cur;
    endfunction

endpackage

`default_nettype wire

// ===== src/tof_zone_target_selector_unit.sv =====
// ----------------------------------------------------------------------------
// tof_zone_target_selector_unit
// Per-zone target selection with running frame statistics.
// ----------------------------------------------------------------------------
// A zone transferred in is held in an input register; slot qualification,
// farthest / nearest selection and the running frame update are done in one
// pass of compares and selects and loaded into the result register when it
// is empty or drains, so the block sustains one zone per cycle while the
// output is not stalled. Output stall passes combinationally to the input
// stall only when both the input register and the result register are
// occupied. Configuration writes take effect on the next zone and should be
// made while no zone is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module tof_zone_target_selector_unit #(
    parameter int MAX_TARGETS = tzts_pkg::MAX_TARGETS,
    parameter int MAX_ZONES   = tzts_pkg::MAX_ZONES
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [tzts_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [tzts_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // zone input
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [tzts_pkg::DIST_W-1:0]  i_distance_0,
    input  wire logic signed [tzts_pkg::DIST_W-1:0]  i_distance_1,
    input  wire logic signed [tzts_pkg::DIST_W-1:0]  i_distance_2,
    input  wire logic signed [tzts_pkg::DIST_W-1:0]  i_distance_3,
    input  wire logic [tzts_pkg::STAT_W-1:0]         i_status_0,
    input  wire logic [tzts_pkg::STAT_W-1:0]         i_status_1,
    input  wire logic [tzts_pkg::STAT_W-1:0]         i_status_2,
    input  wire logic [tzts_pkg::STAT_W-1:0]         i_status_3,
    input  wire logic [tzts_pkg::DCNT_W-1:0]         i_detected_count,
    input  wire logic                                i_last_zone,
    // result output
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [tzts_pkg::FAR_W-1:0]               o_farthest_mm,
    output logic [tzts_pkg::DIST_W-1:0]              o_nearest_mm,
    output logic                                     o_zone_near,
    output logic [tzts_pkg::DIST_W-1:0]              o_frame_closest_mm,
    output logic [tzts_pkg::ZCNT_W-1:0]              o_ground_zone_count,
    output logic [tzts_pkg::ZCNT_W-1:0]              o_nearest_zone_count,
    output logic [tzts_pkg::ZCNT_W-1:0]              o_near_zone_count,
    output logic                                     o_frame_done
);
    import tzts_pkg::*;

    t_cfg      cfg;
    t_zone_res zone_res;
    t_frame    frame_nxt;

    logic      r_s1_valid;
    t_zone_in  r_s1;
    logic      r_out_valid;
    logic [FAR_W-1:0]  r_far;
    logic [DIST_W-1:0] r_nearest;
    logic      r_near;
    t_frame    r_frame_out;
    logic      r_done;

    logic      adv;
    logic      in_xfer;

    tzts_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Flow control: result register drains or is empty -> stage advances
    assign adv        = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !adv;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1.distance <= {i_distance_3, i_distance_2, i_distance_1, i_distance_0};
            r_s1.status   <= {i_status_3, i_status_2, i_status_1, i_status_0};
            r_s1.count    <= i_detected_count;
            r_s1.last     <= i_last_zone;
        end
    end

    tzts_zone_eval #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_eval (
        .i_zone (r_s1),
        .i_cfg  (cfg),
        .o_res  (zone_res)
    );

    tzts_frame_acc #(
        .MAX_ZONES (MAX_ZONES)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_last  (r_s1.last),
        .i_dist  (r_s1.distance),
        .i_res   (zone_res),
        .o_frame (frame_nxt)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_far       <= zone_res.farthest[FAR_W-1:0];
            r_nearest   <= zone_res.nearest;
            r_near      <= zone_res.any;
            r_frame_out <= frame_nxt;
            r_done      <= r_s1.last;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_farthest_mm        = r_far;
    assign o_nearest_mm         = r_nearest;
    assign o_zone_near          = r_near;
    assign o_frame_closest_mm   = r_frame_out.closest;
    assign o_ground_zone_count  = r_frame_out.ground_cnt;
    assign o_nearest_zone_count = r_frame_out.nearest_cnt;
    assign o_near_zone_count    = r_frame_out.near_cnt;
    assign o_frame_done         = r_done;

    // A held zone that cannot advance stays held
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv) |=> r_s1_valid)
        else $error("held zone lost");

    // A zone with no valid target reports no distances
    a_empty_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_zone_near) |-> (o_farthest_mm == '0 && o_nearest_mm == '0))
        else $error("distance reported for empty zone");

    // A frame closest value exists whenever this zone had a nonzero nearest
    a_closest_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_nearest_mm != '0) |-> (o_frame_closest_mm != '0))
        else $error("frame closest unset with nearest present");

endmodule

`default_nettype wire

// ===== src/tzts_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tzts_cfg_regs
// Configuration register bank: slots per zone and the distance window.
// ----------------------------------------------------------------------------
`default_nettype none

module tzts_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tzts_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tzts_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output tzts_pkg::t_cfg                        o_cfg
);
    import tzts_pkg::*;

    t_cfg r_cfg;

    // Register writes; an unused index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.targets  <= TPZ_RESET;
            r_cfg.min_dist <= MIN_DIST_RESET;
            r_cfg.max_dist <= MAX_DIST_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TARGETS:  r_cfg.targets  <= i_cfg_data[TPZ_W-1:0];
                CFG_MIN_DIST: r_cfg.min_dist <= $signed(i_cfg_data[DIST_W-1:0]);
                CFG_MAX_DIST: r_cfg.max_dist <= $signed(i_cfg_data[DIST_W-1:0]);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/tzts_zone_eval.sv =====
// ----------------------------------------------------------------------------
// tzts_zone_eval
// Per-zone target qualification and farthest / nearest selection.
// ----------------------------------------------------------------------------
`default_nettype none

module tzts_zone_eval #(
    parameter int MAX_TARGETS = tzts_pkg::MAX_TARGETS
) (
    input  tzts_pkg::t_zone_in  i_zone,
    input  tzts_pkg::t_cfg      i_cfg,
    output tzts_pkg::t_zone_res o_res
);
    import tzts_pkg::*;

    logic [DCNT_W-1:0]        tpz_ext;
    logic [DCNT_W-1:0]        slot_limit;
    logic [DCNT_W-1:0]        slot_cnt;
    logic [NUM_SLOTS-1:0]     hit;
    logic signed [DIST_W-1:0] far_d;
    logic [DIST_W-1:0]        near_d;

    // Slots examined: min(reported, configured, hardware maximum)
    always_comb begin
        tpz_ext    = {{(DCNT_W-TPZ_W){1'b0}}, i_cfg.targets};
        slot_limit = (tpz_ext < DCNT_W'(MAX_TARGETS)) ? tpz_ext : DCNT_W'(MAX_TARGETS);
        slot_cnt   = (i_zone.count < slot_limit) ? i_zone.count : slot_limit;
    end

    // Slot walk in order; nearest keeps the zero-means-unset rule
    always_comb begin
        logic signed [DIST_W-1:0] d;
        logic                     good;
        far_d  = '0;
        near_d = '0;
        hit    = '0;
        for (int t = 0; t < NUM_SLOTS; t++) begin
            d      = $signed(i_zone.distance[t]);
            good   = (i_zone.status[t] == STATUS_GOOD_A) ||
                     (i_zone.status[t] == STATUS_GOOD_B);
            hit[t] = (DCNT_W'(t) < slot_cnt) && good &&
                     (d > i_cfg.min_dist) && (d < i_cfg.max_dist);
            if (hit[t] && (d > far_d)) begin
                far_d = d;
            end
            if (hit[t]) begin
                near_d = f_unset_min(near_d, i_zone.distance[t]);
            end
        end
    end

    assign o_res.hit      = hit;
    assign o_res.farthest = far_d;
    assign o_res.nearest  = near_d;
    assign o_res.any      = |hit;

endmodule

`default_nettype wire

// ===== src/tzts_frame_acc.sv =====
// ----------------------------------------------------------------------------
// tzts_frame_acc
// Running frame state: closest distance and saturating zone counts.
// ----------------------------------------------------------------------------
`default_nettype none

module tzts_frame_acc #(
    parameter int MAX_ZONES = tzts_pkg::MAX_ZONES
) (
    input  wire logic                                              i_clk,
    input  wire logic                                              i_rst_n,
    input  wire logic                                              i_adv,
    input  wire logic                                              i_last,
    input  wire logic [tzts_pkg::NUM_SLOTS-1:0][tzts_pkg::DIST_W-1:0] i_dist,
    input  tzts_pkg::t_zone_res                                    i_res,
    output tzts_pkg::t_frame                                       o_frame
);
    import tzts_pkg::*;

    t_frame r_frame;
    t_frame n_frame;

    function automatic logic [ZCNT_W-1:0] f_sat_inc(input logic [ZCNT_W-1:0] c);
        return (c < ZCNT_W'(MAX_ZONES)) ? c + 1'b1 : ZCNT_W'(MAX_ZONES);
    endfunction

    // Frame values with this zone folded in
    always_comb begin
        n_frame = r_frame;
        for (int t = 0; t < NUM_SLOTS; t++) begin
            if (i_res.hit[t]) begin
                n_frame.closest = f_unset_min(n_frame.closest, i_dist[t]);
            end
        end
        if (i_res.farthest != '0) begin
            n_frame.ground_cnt = f_sat_inc(r_frame.ground_cnt);
        end
        if (i_res.nearest != '0) begin
            n_frame.nearest_cnt = f_sat_inc(r_frame.nearest_cnt);
        end
        if (i_res.any) begin
            n_frame.near_cnt = f_sat_inc(r_frame.near_cnt);
        end
    end

    // State update; cleared after the frame's last zone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
        end else if (i_adv) begin
            r_frame <= i_last ? '0 : n_frame;
        end
    end

    assign o_frame = n_frame;

    // Frame end clears all running state
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_last) |=> (r_frame == '0))
        else $error("frame state not cleared after last zone");

    // Counts never pass the saturation point
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frame.ground_cnt <= ZCNT_W'(MAX_ZONES)) &&
        (r_frame.nearest_cnt <= ZCNT_W'(MAX_ZONES)) &&
        (r_frame.near_cnt <= ZCNT_W'(MAX_ZONES)))
        else $error("zone count beyond saturation");

    // A zone with a farthest value always has a valid target
    a_ground_le_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame.ground_cnt <= r_frame.near_cnt)
        else $error("ground count exceeds near count");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ToF zone target selector. A short table of
// hand-picked zones (register extremes, status filtering, count clamping,
// negative and zero distances) is followed by random frames under several
// register settings. Every zone is scored by a behavioural selector in the
// bench and each result transfer is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    import tzts_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTED = 10;
    localparam int PHASES       = 5;
    localparam int PHASE_ZONES  = 120;

    typedef struct packed {
        logic [FAR_W-1:0]  farthest;
        logic [DIST_W-1:0] nearest;
        logic              zone_near;
        logic [DIST_W-1:0] closest;
        logic [ZCNT_W-1:0] ground_cnt;
        logic [ZCNT_W-1:0] nearest_cnt;
        logic [ZCNT_W-1:0] near_cnt;
        logic              done;
    } zone_summary_t;

    typedef struct {
        logic [TPZ_W-1:0]         tpz;
        logic signed [DIST_W-1:0] min_d;
        logic signed [DIST_W-1:0] max_d;
        t_zone_in                 zone;
        bit                       typed;
        zone_summary_t            summary;
    } dir_row_t;

    // Clock, reset and DUT-facing signals
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    t_cfg_idx              cfg_idx   = CFG_TARGETS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    t_zone_in              zone_bus  = '0;
    logic                  out_stall = 1'b0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [FAR_W-1:0]      o_farthest_mm;
    logic [DIST_W-1:0]     o_nearest_mm;
    logic                  o_zone_near;
    logic [DIST_W-1:0]     o_frame_closest_mm;
    logic [ZCNT_W-1:0]     o_ground_zone_count;
    logic [ZCNT_W-1:0]     o_nearest_zone_count;
    logic [ZCNT_W-1:0]     o_near_zone_count;
    logic                  o_frame_done;

    // Bench copy of the registers and running frame values
    int                    cfg_targets = TPZ_RESET;
    int                    cfg_min     = MIN_DIST_RESET;
    int                    cfg_max     = MAX_DIST_RESET;
    logic [DIST_W-1:0]     frame_closest = '0;
    int                    ground_seen   = 0;
    int                    nearest_seen  = 0;
    int                    near_seen     = 0;

    zone_summary_t         pending_summaries[$];
    int                    mismatch_cnt = 0;
    int                    result_cnt   = 0;
    int                    cycle_cnt    = 0;
    int                    burst_left   = 0;
    int                    stall_mode   = 0;
    int                    stall_run    = 0;

    tof_zone_target_selector_unit dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_we             (cfg_we),
        .i_cfg_index          (cfg_idx),
        .i_cfg_data           (cfg_data),
        .i_in_valid           (in_valid),
        .o_in_stall           (o_in_stall),
        .i_distance_0         (zone_bus.distance[0]),
        .i_distance_1         (zone_bus.distance[1]),
        .i_distance_2         (zone_bus.distance[2]),
        .i_distance_3         (zone_bus.distance[3]),
        .i_status_0           (zone_bus.status[0]),
        .i_status_1           (zone_bus.status[1]),
        .i_status_2           (zone_bus.status[2]),
        .i_status_3           (zone_bus.status[3]),
        .i_detected_count     (zone_bus.count),
        .i_last_zone          (zone_bus.last),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (out_stall),
        .o_farthest_mm        (o_farthest_mm),
        .o_nearest_mm         (o_nearest_mm),
        .o_zone_near          (o_zone_near),
        .o_frame_closest_mm   (o_frame_closest_mm),
        .o_ground_zone_count  (o_ground_zone_count),
        .o_nearest_zone_count (o_nearest_zone_count),
        .o_near_zone_count    (o_near_zone_count),
        .o_frame_done         (o_frame_done)
    );

    always #1 clk = ~clk;

    // Scores one zone and advances the running frame values
    function automatic zone_summary_t select_targets(input t_zone_in z);
        zone_summary_t     r;
        int                n;
        int                t;
        int                d;
        int                far_d;
        logic [DIST_W-1:0] ud;
        logic [DIST_W-1:0] near_d;
        bit                hit;
        far_d  = 0;
        near_d = '0;
        hit    = 1'b0;
        n = int'(z.count);
        if (n > cfg_targets) n = cfg_targets;
        if (n > MAX_TARGETS) n = MAX_TARGETS;
        for (t = 0; t < n; t++) begin
            d  = int'($signed(z.distance[t]));
            ud = z.distance[t];
            if ((z.status[t] == STATUS_GOOD_A || z.status[t] == STATUS_GOOD_B) &&
                d > cfg_min && d < cfg_max) begin
                hit = 1'b1;
                if (d > far_d) far_d = d;
                // zero is "unset", and the minimum is taken on the raw pattern
                if (near_d == '0 || ud < near_d) near_d = ud;
                if (frame_closest == '0 || ud < frame_closest) frame_closest = ud;
            end
        end
        if (far_d != 0 && ground_seen < MAX_ZONES) ground_seen++;
        if (near_d != '0 && nearest_seen < MAX_ZONES) nearest_seen++;
        if (hit && near_seen < MAX_ZONES) near_seen++;
        r.farthest    = far_d[FAR_W-1:0];
        r.nearest     = near_d;
        r.zone_near   = hit;
        r.closest     = frame_closest;
        r.ground_cnt  = ground_seen[ZCNT_W-1:0];
        r.nearest_cnt = nearest_seen[ZCNT_W-1:0];
        r.near_cnt    = near_seen[ZCNT_W-1:0];
        r.done        = z.last;
        // frame closes: running values start again
        if (z.last) begin
            frame_closest = '0;
            ground_seen   = 0;
            nearest_seen  = 0;
            near_seen     = 0;
        end
        return r;
    endfunction

    function automatic zone_summary_t zone_summary(input int far_d, input int near_d,
                                                   input bit hit, input int closest,
                                                   input int g, input int n, input int nz,
                                                   input bit done);
        zone_summary_t r;
        r.farthest    = far_d[FAR_W-1:0];
        r.nearest     = near_d[DIST_W-1:0];
        r.zone_near   = hit;
        r.closest     = closest[DIST_W-1:0];
        r.ground_cnt  = g[ZCNT_W-1:0];
        r.nearest_cnt = n[ZCNT_W-1:0];
        r.near_cnt    = nz[ZCNT_W-1:0];
        r.done        = done;
        return r;
    endfunction

    function automatic dir_row_t dir_row(input int tpz, input int mn, input int mx,
                                         input int d0, input int d1, input int d2,
                                         input int d3, input int s0, input int s1,
                                         input int s2, input int s3, input int cnt,
                                         input bit last, input bit typed,
                                         input zone_summary_t summary);
        dir_row_t r;
        r.tpz              = tpz[TPZ_W-1:0];
        r.min_d            = mn[DIST_W-1:0];
        r.max_d            = mx[DIST_W-1:0];
        r.zone.distance[0] = d0[DIST_W-1:0];
        r.zone.distance[1] = d1[DIST_W-1:0];
        r.zone.distance[2] = d2[DIST_W-1:0];
        r.zone.distance[3] = d3[DIST_W-1:0];
        r.zone.status[0]   = s0[STAT_W-1:0];
        r.zone.status[1]   = s1[STAT_W-1:0];
        r.zone.status[2]   = s2[STAT_W-1:0];
        r.zone.status[3]   = s3[STAT_W-1:0];
        r.zone.count       = cnt[DCNT_W-1:0];
        r.zone.last        = last;
        r.typed            = typed;
        r.summary          = summary;
        return r;
    endfunction

    // Random zone, mostly good statuses and distances inside the window
    function automatic t_zone_in random_zone(input bit last);
        t_zone_in z;
        int       t;
        int       v;
        int       span;
        z = '0;
        span = cfg_max - cfg_min;
        for (t = 0; t < NUM_SLOTS; t++) begin
            if ($urandom_range(0, 9) < 7)
                z.status[t] = $urandom_range(0, 1) ? STATUS_GOOD_A : STATUS_GOOD_B;
            else
                z.status[t] = STAT_W'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    if (span > 1)
                        v = cfg_min + 1 + int'($urandom_range(0, span - 2));
                    else
                        v = $urandom_range(0, 65535);
                end
                6: begin
                    case ($urandom_range(0, 4))
                        0:       v = cfg_min;
                        1:       v = cfg_min + 1;
                        2:       v = cfg_max - 1;
                        3:       v = cfg_max;
                        default: v = 0;
                    endcase
                end
                default: v = $urandom_range(0, 65535);
            endcase
            z.distance[t] = v[DIST_W-1:0];
        end
        z.count = DCNT_W'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 4)
                                                      : $urandom_range(0, 255));
        z.last  = last;
        return z;
    endfunction

    // Drives one zone, with a random gap at the start of each burst
    task automatic send_zone(input t_zone_in z, input bit typed, input zone_summary_t typed_sum);
        int gap;
        zone_summary_t sum;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) begin
                    zone_bus <= t_zone_in'({$urandom, $urandom, $urandom});
                    @(negedge clk);
                end
            end
        end
        zone_bus <= z;
        in_valid <= 1'b1;
        do @(posedge clk); while (o_in_stall);
        sum = select_targets(z);
        pending_summaries.push_back(typed ? typed_sum : sum);
        burst_left--;
        @(negedge clk);
    endtask

    // Drop valid and let every outstanding result drain
    task automatic drain;
        in_valid   <= 1'b0;
        burst_left  = 0;
        while (pending_summaries.size() != 0) @(negedge clk);
    endtask

    task automatic program_regs(input logic [TPZ_W-1:0] tpz,
                                input logic signed [DIST_W-1:0] mn,
                                input logic signed [DIST_W-1:0] mx);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_TARGETS;
        cfg_data <= CFG_DATA_W'(tpz);
        @(negedge clk);
        cfg_idx  <= CFG_MIN_DIST;
        cfg_data <= mn;
        @(negedge clk);
        cfg_idx  <= CFG_MAX_DIST;
        cfg_data <= mx;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cfg_targets = int'(tpz);
        cfg_min     = int'(mn);
        cfg_max     = int'(mx);
    endtask

    task automatic check_field(input string fname, input logic [DIST_W-1:0] want,
                               input logic [DIST_W-1:0] got);
        if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTED)
                $display("result %0d: %s expected 'h%h, got 'h%h",
                         result_cnt, fname, want, got);
        end
    endtask

    // Receiver stall: stretches of no stall, light, heavy and solid stall
    always @(negedge clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(5, 40);
        end else begin
            stall_run--;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= 1'b1;
        endcase
    end

    // Result transfers against the oldest pending summary
    always @(posedge clk) begin
        zone_summary_t want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (pending_summaries.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTED)
                    $display("result %0d arrived with no zone outstanding", result_cnt);
            end else begin
                want = pending_summaries.pop_front();
                check_field("farthest_mm", DIST_W'(want.farthest), DIST_W'(o_farthest_mm));
                check_field("nearest_mm", want.nearest, o_nearest_mm);
                check_field("zone_near", DIST_W'(want.zone_near), DIST_W'(o_zone_near));
                check_field("frame_closest_mm", want.closest, o_frame_closest_mm);
                check_field("ground_zone_count", DIST_W'(want.ground_cnt),
                            DIST_W'(o_ground_zone_count));
                check_field("nearest_zone_count", DIST_W'(want.nearest_cnt),
                            DIST_W'(o_nearest_zone_count));
                check_field("near_zone_count", DIST_W'(want.near_cnt),
                            DIST_W'(o_near_zone_count));
                check_field("frame_done", DIST_W'(want.done), DIST_W'(o_frame_done));
            end
            result_cnt++;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus
    initial begin
        dir_row_t      dir_tbl[18];
        zone_summary_t none;
        int            ph;
        int            sent;
        int            flen;
        int            k;
        int            mn;
        int            mx;
        int            tpz;
        none = '0;

        // reset settings: window (0, 4000), four slots
        dir_tbl[0]  = dir_row(4, 0, 4000, 100, 200, 300, 400, 0, 0, 0, 0, 4, 0,
                              1, zone_summary(0, 0, 0, 0, 0, 0, 0, 0));
        dir_tbl[1]  = dir_row(4, 0, 4000, 100, 200, 300, 400, 5, 9, 5, 9, 0, 0,
                              1, zone_summary(0, 0, 0, 0, 0, 0, 0, 0));
        dir_tbl[2]  = dir_row(4, 0, 4000, 100, 200, 300, 50, 5, 9, 5, 9, 4, 0,
                              1, zone_summary(300, 50, 1, 50, 1, 1, 1, 0));
        // window edges, count far above the slot limit
        dir_tbl[3]  = dir_row(4, 0, 4000, 3999, 4000, 1, 0, 5, 5, 5, 5, 255, 0, 0, none);
        // near-miss status codes
        dir_tbl[4]  = dir_row(4, 0, 4000, 500, 600, 700, 800, 4, 6, 8, 10, 4, 0, 0, none);
        dir_tbl[5]  = dir_row(4, 0, 4000, 1000, 1500, -1, 32767, 9, 255, 5, 5, 2, 0, 0, none);
        dir_tbl[6]  = dir_row(4, 0, 4000, 2000, 10, 20, 30, 5, 9, 9, 5, 3, 1, 0, none);
        dir_tbl[7]  = dir_row(4, 0, 4000, 2500, 2600, 2700, 2800, 9, 9, 9, 9, 4, 1, 0, none);
        // no slots examined at all
        dir_tbl[8]  = dir_row(0, 0, 4000, 100, 200, 300, 400, 5, 5, 5, 5, 4, 1,
                              1, zone_summary(0, 0, 0, 0, 0, 0, 0, 1));
        // full window: negatives count by their raw pattern
        dir_tbl[9]  = dir_row(1, -32768, 32767, -5, 100, 200, 300, 5, 5, 5, 5, 4, 0,
                              0, none);
        dir_tbl[10] = dir_row(2, -32768, 32767, -32768, 32767, 7, 8, 5, 9, 5, 9, 4, 0,
                              0, none);
        dir_tbl[11] = dir_row(4, -32768, 32767, 0, -1, 32766, -32767, 9, 9, 9, 9, 4, 0,
                              0, none);
        // zero distances are valid here but never set a minimum
        dir_tbl[12] = dir_row(4, -32768, 32767, 0, 0, 0, 0, 5, 5, 5, 5, 4, 0, 0, none);
        dir_tbl[13] = dir_row(4, -32768, 32767, -32767, -2, 5, 7, 5, 9, 5, 9, 4, 1, 0, none);
        // inverted window rejects everything
        dir_tbl[14] = dir_row(3, 32767, -32768, 10, 0, -10, 32000, 5, 5, 9, 9, 4, 0,
                              1, zone_summary(0, 0, 0, 0, 0, 0, 0, 0));
        // slot register above the slot count
        dir_tbl[15] = dir_row(7, -100, 100, -99, 99, -100, 100, 5, 9, 5, 9, 8, 0, 0, none);
        dir_tbl[16] = dir_row(7, -100, 100, 50, 60, 70, 80, 1, 2, 3, 9, 3, 0, 0, none);
        dir_tbl[17] = dir_row(7, -100, 100, -50, 0, 40, 99, 9, 5, 9, 5, 4, 1, 0, none);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tbl[i]) begin
            if (int'(dir_tbl[i].tpz) != cfg_targets || int'(dir_tbl[i].min_d) != cfg_min ||
                int'(dir_tbl[i].max_d) != cfg_max) begin
                drain();
                program_regs(dir_tbl[i].tpz, dir_tbl[i].min_d, dir_tbl[i].max_d);
            end
            send_zone(dir_tbl[i].zone, dir_tbl[i].typed, dir_tbl[i].summary);
        end

        // Random frames, one register setting per phase
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                tpz = 4; mn = -32768; mx = 32767;
            end else if (ph == 1) begin
                tpz = 1; mn = 0; mx = 4000;
            end else begin
                case ($urandom_range(0, 9))
                    0:       tpz = 0;
                    1:       tpz = $urandom_range(5, 7);
                    default: tpz = $urandom_range(1, 4);
                endcase
                case ($urandom_range(0, 5))
                    0: begin
                        mn = -32768; mx = 32767;
                    end
                    1: begin
                        mn = int'($signed(16'($urandom_range(0, 65535))));
                        mx = int'($signed(16'($urandom_range(0, 65535))));
                    end
                    default: begin
                        mn = int'($urandom_range(0, 1200)) - 400;
                        mx = mn + int'($urandom_range(2, 6000));
                    end
                endcase
            end
            drain();
            program_regs(tpz[TPZ_W-1:0], mn[DIST_W-1:0], mx[DIST_W-1:0]);
            sent = 0;
            while (sent < PHASE_ZONES) begin
                // occasional long frame to push the counts into saturation
                flen = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 140)
                                                   : $urandom_range(1, 16);
                if (flen > PHASE_ZONES - sent) flen = PHASE_ZONES - sent;
                for (k = 0; k < flen; k++) begin
                    send_zone(random_zone(k == flen - 1), 1'b0, none);
                    sent++;
                end
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (mismatch_cnt == 0 && pending_summaries.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/tzts_pkg.sv
src/tzts_cfg_regs.sv
src/tzts_zone_eval.sv
src/tzts_frame_acc.sv
src/tof_zone_target_selector_unit.sv
bench/tb_top.sv
